@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by dag_topological_sort.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dts_pkg.sv @@
// Shared constants and types for the topological sort block.
package dts_pkg;

  localparam int ROW_W         = 32;
  localparam int VTX_W         = 5;
  localparam int POS_W         = 5;
  localparam int OUT_DATA_W    = 16;
  localparam int DEF_MAX_NODES = 32;

  // Control from the sequencer to every column lane.
  typedef struct packed {
    logic clear;
    logic add;
    logic dec;
  } lane_ctrl_t;

  // Status from one column lane.
  typedef struct packed {
    logic zero;
    logic to_zero;
  } lane_stat_t;

endpackage

@@ hw/rtl/dts_lane.sv @@
// One column lane: in-degree counter of a single node.
module dts_lane import dts_pkg::*; #(
  parameter int CNT_W = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  logic       col_bit,
  input  logic       active,
  output lane_stat_t stat
);

  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      cnt <= '0;
    end else if (ctrl.add && col_bit) begin
      cnt <= cnt + CNT_W'(1);
    end else if (ctrl.dec && col_bit && active && cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign stat.zero    = (cnt == '0);
  // this child drops to zero if the popped node points at it
  assign stat.to_zero = col_bit && active && (cnt == CNT_W'(1));

endmodule

@@ hw/rtl/dts_pick.sv @@
// Pick logic: picks the lowest pending node to push next.
module dts_pick import dts_pkg::*; #(
  parameter int N  = 32,
  parameter int IW = 5
) (
  input  logic [N-1:0]  mask,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (mask[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

@@ hw/rtl/dag_topological_sort.sv @@
// Rows load one per cycle while s_tready is high; after the last row the sort seeds, then
// per node does one push, one pop and one empty scan, then sends N result beats.
// One graph at a time: input waits from the last row to the last beat.
// Reset: rst is synchronous, active high; clears counters, lanes and the output beat.
// Adjacency, stack and order storage need no reset.
module dag_topological_sort import dts_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ROW_W-1:0]      s_tdata,   // [31:0] row_bits
  input  logic                  s_tlast,   // last_row
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] vertex, [9:5] position, [15:10] zero
  output logic                  m_tuser,   // placed
  output logic                  m_tlast    // last_slot
);

`include "assert_macros.svh"

  localparam int NODE_CAP = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int IDX_W    = $clog2(NODE_CAP);
  localparam int CNT_W    = $clog2(NODE_CAP + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    rows_loaded;
  logic [CNT_W-1:0]    node_cnt;
  logic [NODE_CAP-1:0] colmask;
  logic [NODE_CAP-1:0] pend;
  logic [CNT_W-1:0]    depth;
  logic [CNT_W-1:0]    filled;
  logic [CNT_W-1:0]    emit_idx;

  logic [ROW_W-1:0] adj   [NODE_CAP];
  logic [IDX_W-1:0] stk   [NODE_CAP];
  logic [IDX_W-1:0] slots [NODE_CAP];

  logic                in_acc;
  logic                row_room;
  logic [CNT_W-1:0]    rows_next;
  logic [NODE_CAP-1:0] colmask_next;
  logic [CNT_W-1:0]    depth_m1;
  logic [IDX_W-1:0]    stk_top;
  logic [ROW_W-1:0]    adj_top;
  logic                out_load;
  logic                emit_last;
  logic                pick_found;
  logic [IDX_W-1:0]    pick_idx;
  lane_ctrl_t          lane_ctrl;
  lane_stat_t          lane_stat [NODE_CAP];
  logic [NODE_CAP-1:0] zero_vec;
  logic [NODE_CAP-1:0] to_zero_vec;
  logic [NODE_CAP-1:0] lane_bit;

  assign s_tready  = (state == S_LOAD);
  assign in_acc    = s_tvalid && s_tready;
  assign row_room  = (rows_loaded < CNT_W'(NODE_CAP));
  assign rows_next = row_room ? rows_loaded + CNT_W'(1) : rows_loaded;

  always_comb begin
    for (int j = 0; j < NODE_CAP; j++) begin
      colmask_next[j] = (CNT_W'(j) < rows_next);
    end
  end

  assign depth_m1 = depth - CNT_W'(1);
  assign stk_top  = stk[depth_m1[IDX_W-1:0]];
  assign adj_top  = adj[stk_top];

  assign out_load  = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign emit_last = (emit_idx + CNT_W'(1) == node_cnt);

  assign lane_ctrl.clear = out_load && emit_last;
  assign lane_ctrl.add   = in_acc && row_room;
  assign lane_ctrl.dec   = (state == S_POP);

  for (genvar j = 0; j < NODE_CAP; j++) begin : g_lane
    assign lane_bit[j] = (state == S_LOAD) ? s_tdata[j] : adj_top[j];

    dts_lane #(
      .CNT_W (CNT_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .col_bit (lane_bit[j]),
      .active  (colmask[j]),
      .stat    (lane_stat[j])
    );

    assign zero_vec[j]    = lane_stat[j].zero;
    assign to_zero_vec[j] = lane_stat[j].to_zero;
  end

  dts_pick #(
    .N  (NODE_CAP),
    .IW (IDX_W)
  ) u_pick (
    .mask  (pend),
    .found (pick_found),
    .idx   (pick_idx)
  );

  // storage without reset
  always_ff @(posedge clk) begin
    if (in_acc && row_room) begin
      adj[rows_loaded[IDX_W-1:0]] <= s_tdata;
    end
    if (state == S_PUSH && pick_found) begin
      stk[depth[IDX_W-1:0]] <= pick_idx;
    end
    if (state == S_POP) begin
      slots[filled[IDX_W-1:0]] <= stk_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      rows_loaded <= '0;
      node_cnt    <= '0;
      colmask     <= '0;
      pend        <= '0;
      depth       <= '0;
      filled      <= '0;
      emit_idx    <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (s_tlast) begin
              node_cnt    <= rows_next;
              colmask     <= colmask_next;
              rows_loaded <= '0;
              state       <= S_SEED;
            end else begin
              rows_loaded <= rows_next;
            end
          end
        end
        S_SEED: begin
          pend   <= colmask & zero_vec;
          depth  <= '0;
          filled <= '0;
          state  <= S_PUSH;
        end
        S_PUSH: begin
          // ascending push order leaves the highest ready node on top
          if (pick_found) begin
            depth          <= depth + CNT_W'(1);
            pend[pick_idx] <= 1'b0;
          end else if (depth != '0 && filled < node_cnt) begin
            state <= S_POP;
          end else begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_POP: begin
          depth  <= depth_m1;
          filled <= filled + CNT_W'(1);
          pend   <= to_zero_vec;
          state  <= S_PUSH;
        end
        S_EMIT: begin
          if (out_load) begin
            emit_idx <= emit_idx + CNT_W'(1);
            if (emit_last) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({POS_W'(emit_idx),
                              (emit_idx < filled) ? VTX_W'(slots[emit_idx[IDX_W-1:0]])
                                                  : VTX_W'(0)});
      m_tuser <= (emit_idx < filled);
      m_tlast <= emit_last;
    end
  end

  `ASSERT_ALWAYS(a_depth_cap, depth <= CNT_W'(NODE_CAP), "ready stack overflow")
  `ASSERT_ALWAYS(a_pop_nonempty, state != S_POP || depth != '0, "pop from empty stack")
  `ASSERT_ALWAYS(a_filled_le_n, state == S_LOAD || state == S_SEED || filled <= node_cnt,
                 "more slots filled than nodes")
  `ASSERT_NEXT(a_last_clears, out_load && emit_last, state == S_LOAD && rows_loaded == '0,
               "sort did not return to loading")

endmodule
